// ===== sv/usrc_pkg.sv =====
// ----------------------------------------------------------------------------
// usrc_pkg
// Shared types, constants and helpers for the UTF-8 symbol range checker.
// ----------------------------------------------------------------------------
`default_nettype none

package usrc_pkg;

   localparam int unsigned MaxSymbolBytes = 4;
   localparam int unsigned RangeCount     = 7;
   localparam int unsigned CodePointWidth = 21;
   localparam int unsigned LengthWidth    = 3;
   localparam int unsigned RangeIdxWidth  = 3;

   localparam logic [RangeIdxWidth-1:0] NoRange     = 3'd7;
   localparam logic [RangeCount-1:0]    MaskDefault = 7'h7F;

   localparam logic [7:0] LeadMask2 = 8'hE0;
   localparam logic [7:0] LeadCode2 = 8'hC0;
   localparam logic [7:0] LeadMask3 = 8'hF0;
   localparam logic [7:0] LeadCode3 = 8'hE0;
   localparam logic [7:0] LeadMask4 = 8'hF8;
   localparam logic [7:0] LeadCode4 = 8'hF0;
   localparam logic [7:0] ContMask  = 8'hC0;
   localparam logic [7:0] ContCode  = 8'h80;

   localparam logic [2:0] LeadBad  = 3'd0;
   localparam logic [2:0] LeadOne  = 3'd1;
   localparam logic [2:0] LeadTwo  = 3'd2;
   localparam logic [2:0] LeadThree = 3'd3;
   localparam logic [2:0] LeadFour = 3'd4;

   localparam logic [RangeCount-1:0][CodePointWidth-1:0] RangeLo = {
      21'h02F00, 21'h04E00, 21'h03400, 21'h02A00, 21'h027C0, 21'h02200, 21'h03000
   };
   localparam logic [RangeCount-1:0][CodePointWidth-1:0] RangeHi = {
      21'h02FDF, 21'h09FFF, 21'h04DBF, 21'h02AFF, 21'h027EF, 21'h022FF, 21'h0303F
   };

   typedef struct packed {
      logic [3:0][7:0]         bytes;
      logic [3:0][2:0]         lead;
      logic [3:0]              cont;
      logic [LengthWidth-1:0]  len;
      logic                    len_ok;
   } class_type;

   typedef struct packed {
      logic                      ok;
      logic [CodePointWidth-1:0] cp;
   } decode_type;

   typedef struct packed {
      logic                      ok;
      logic [CodePointWidth-1:0] cp;
      logic [RangeCount-1:0]     hit;
   } match_type;

   function automatic logic [2:0] lead_size(input logic [7:0] b);
      logic [2:0] n;
      if (!b[7]) begin
         n = LeadOne;
      end else if ((b & LeadMask2) == LeadCode2) begin
         n = LeadTwo;
      end else if ((b & LeadMask3) == LeadCode3) begin
         n = LeadThree;
      end else if ((b & LeadMask4) == LeadCode4) begin
         n = LeadFour;
      end else begin
         n = LeadBad;
      end
      return n;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b & ContMask) == ContCode;
   endfunction

endpackage

`default_nettype wire

// ===== sv/usrc_classify.sv =====
// ----------------------------------------------------------------------------
// usrc_classify
// First stage: registers the symbol with per-byte lead class and
// continuation flags and the length check.
// ----------------------------------------------------------------------------
`default_nettype none

module usrc_classify (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_stall,
   input  wire logic [7:0]                        byte_zero,
   input  wire logic [7:0]                        byte_one,
   input  wire logic [7:0]                        byte_two,
   input  wire logic [7:0]                        byte_three,
   input  wire logic [usrc_pkg::LengthWidth-1:0]  symbol_length,
   output logic                                   out_valid,
   input  wire logic                              out_stall,
   output usrc_pkg::class_type                    out_data
);

   logic                valid_ff;
   logic                valid_in;
   usrc_pkg::class_type data_ff;
   usrc_pkg::class_type data_in;
   logic                hold;

   assign hold     = valid_ff & out_stall;
   assign in_stall = hold;
   assign valid_in = hold ? valid_ff : in_valid;

   always_comb begin
      data_in.bytes  = {byte_three, byte_two, byte_one, byte_zero};
      for (int i = 0; i < 4; i++) begin
         data_in.lead[i] = usrc_pkg::lead_size(data_in.bytes[i]);
         data_in.cont[i] = usrc_pkg::is_cont(data_in.bytes[i]);
      end
      data_in.len    = symbol_length;
      data_in.len_ok = (symbol_length != '0) &&
                       ({29'd0, symbol_length} <= usrc_pkg::MaxSymbolBytes);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/usrc_validate.sv =====
// ----------------------------------------------------------------------------
// usrc_validate
// Second stage: walks the sequences within the length and decodes the
// first character's code point.
// ----------------------------------------------------------------------------
`default_nettype none

module usrc_validate (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire usrc_pkg::class_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output usrc_pkg::decode_type      out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   usrc_pkg::decode_type data_ff;
   usrc_pkg::decode_type data_in;
   logic                 hold;
   logic                 ok;
   logic [2:0]           pos;
   logic [2:0]           n;
   logic [usrc_pkg::CodePointWidth-1:0] cp;

   assign hold     = valid_ff & out_stall;
   assign in_stall = hold;
   assign valid_in = hold ? valid_ff : in_valid;

   always_comb begin
      ok  = in_data.len_ok;
      pos = '0;
      n   = '0;
      for (int step = 0; step < 4; step++) begin
         if (ok && (pos < in_data.len)) begin
            n = in_data.lead[pos[1:0]];
            if ((n == usrc_pkg::LeadBad) ||
                (({1'b0, pos} + {1'b0, n}) > {1'b0, in_data.len})) begin
               ok = 1'b0;
            end else begin
               for (int k = 1; k < 4; k++) begin
                  if ((3'(k) < n) && !in_data.cont[2'(pos + 3'(k))]) begin
                     ok = 1'b0;
                  end
               end
               pos = pos + n;
            end
         end
      end
   end

   always_comb begin
      case (in_data.lead[0])
         usrc_pkg::LeadOne: begin
            cp = {13'd0, in_data.bytes[0]};
         end
         usrc_pkg::LeadTwo: begin
            cp = {10'd0, in_data.bytes[0][4:0], in_data.bytes[1][5:0]};
         end
         usrc_pkg::LeadThree: begin
            cp = {5'd0, in_data.bytes[0][3:0], in_data.bytes[1][5:0],
                  in_data.bytes[2][5:0]};
         end
         usrc_pkg::LeadFour: begin
            cp = {in_data.bytes[0][2:0], in_data.bytes[1][5:0],
                  in_data.bytes[2][5:0], in_data.bytes[3][5:0]};
         end
         default: begin
            cp = '0;
         end
      endcase
      data_in.ok = ok;
      data_in.cp = ok ? cp : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/usrc_range_compare.sv =====
// ----------------------------------------------------------------------------
// usrc_range_compare
// Third stage: compares the code point against every enabled range.
// ----------------------------------------------------------------------------
`default_nettype none

module usrc_range_compare (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [usrc_pkg::RangeCount-1:0]  range_mask,
   input  wire logic                             in_valid,
   output logic                                  in_stall,
   input  wire usrc_pkg::decode_type             in_data,
   output logic                                  out_valid,
   input  wire logic                             out_stall,
   output usrc_pkg::match_type                   out_data
);

   logic                valid_ff;
   logic                valid_in;
   usrc_pkg::match_type data_ff;
   usrc_pkg::match_type data_in;
   logic                hold;

   assign hold     = valid_ff & out_stall;
   assign in_stall = hold;
   assign valid_in = hold ? valid_ff : in_valid;

   always_comb begin
      data_in.ok = in_data.ok;
      data_in.cp = in_data.cp;
      for (int r = 0; r < usrc_pkg::RangeCount; r++) begin
         data_in.hit[r] = in_data.ok && range_mask[r] &&
                          (in_data.cp >= usrc_pkg::RangeLo[r]) &&
                          (in_data.cp <= usrc_pkg::RangeHi[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/usrc_verdict.sv =====
// ----------------------------------------------------------------------------
// usrc_verdict
// Last stage: picks the first matching range and holds the result for the
// response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module usrc_verdict (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_stall,
   input  wire usrc_pkg::match_type                   in_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_symbol_accepted,
   output logic                                       rsp_utf8_well_formed,
   output logic [usrc_pkg::CodePointWidth-1:0]        rsp_code_point,
   output logic [usrc_pkg::RangeIdxWidth-1:0]         rsp_matched_range
);

   logic                                valid_ff;
   logic                                valid_in;
   logic                                hold;
   logic [usrc_pkg::RangeIdxWidth-1:0]  match_in;
   logic                                accepted_ff;
   logic                                well_formed_ff;
   logic [usrc_pkg::CodePointWidth-1:0] cp_ff;
   logic [usrc_pkg::RangeIdxWidth-1:0]  match_ff;

   assign hold     = valid_ff & rsp_stall;
   assign in_stall = hold;
   assign valid_in = hold ? valid_ff : in_valid;

   // lowest index wins
   always_comb begin
      match_in = usrc_pkg::NoRange;
      for (int r = usrc_pkg::RangeCount - 1; r >= 0; r--) begin
         if (in_data.hit[r]) begin
            match_in = usrc_pkg::RangeIdxWidth'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && in_valid) begin
         accepted_ff    <= in_data.ok && (match_in != usrc_pkg::NoRange);
         well_formed_ff <= in_data.ok;
         cp_ff          <= in_data.cp;
         match_ff       <= match_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_symbol_accepted  = accepted_ff;
   assign rsp_utf8_well_formed = well_formed_ff;
   assign rsp_code_point       = cp_ff;
   assign rsp_matched_range    = match_ff;

endmodule

`default_nettype wire

// ===== sv/utf8_symbol_range_checker_unit.sv =====
// Stages: classify, validate, range compare and verdict, each registered.
// Throughput: one transaction per cycle; the four stage registers each
// hold while the stage after them is stalled.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// range enable mask to all ranges enabled.
// ----------------------------------------------------------------------------
// utf8_symbol_range_checker_unit
// Checks a one to four byte UTF-8 symbol, decodes its first code point and
// matches it against seven fixed, individually enabled code point ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_symbol_range_checker_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [7:0]                            req_byte_zero,
   input  wire logic [7:0]                            req_byte_one,
   input  wire logic [7:0]                            req_byte_two,
   input  wire logic [7:0]                            req_byte_three,
   input  wire logic [usrc_pkg::LengthWidth-1:0]      req_symbol_length,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_symbol_accepted,
   output logic                                       rsp_utf8_well_formed,
   output logic [usrc_pkg::CodePointWidth-1:0]        rsp_code_point,
   output logic [usrc_pkg::RangeIdxWidth-1:0]         rsp_matched_range,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [usrc_pkg::RangeCount-1:0]       csr_range_enable_mask
);

   logic [usrc_pkg::RangeCount-1:0] mask_ff;

   logic                 s1_valid;
   logic                 s1_stall;
   usrc_pkg::class_type  s1_data;
   logic                 s2_valid;
   logic                 s2_stall;
   usrc_pkg::decode_type s2_data;
   logic                 s3_valid;
   logic                 s3_stall;
   usrc_pkg::match_type  s3_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= usrc_pkg::MaskDefault;
      end else if (csr_valid && csr_ready) begin
         mask_ff <= csr_range_enable_mask;
      end
   end

   usrc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .byte_zero     (req_byte_zero),
      .byte_one      (req_byte_one),
      .byte_two      (req_byte_two),
      .byte_three    (req_byte_three),
      .symbol_length (req_symbol_length),
      .out_valid     (s1_valid),
      .out_stall     (s1_stall),
      .out_data      (s1_data)
   );

   usrc_validate u_validate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_data  (s2_data)
   );

   usrc_range_compare u_range_compare (
      .clock      (clock),
      .reset      (reset),
      .range_mask (mask_ff),
      .in_valid   (s2_valid),
      .in_stall   (s2_stall),
      .in_data    (s2_data),
      .out_valid  (s3_valid),
      .out_stall  (s3_stall),
      .out_data   (s3_data)
   );

   usrc_verdict u_verdict (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (s3_valid),
      .in_stall             (s3_stall),
      .in_data              (s3_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_symbol_accepted  (rsp_symbol_accepted),
      .rsp_utf8_well_formed (rsp_utf8_well_formed),
      .rsp_code_point       (rsp_code_point),
      .rsp_matched_range    (rsp_matched_range)
   );

endmodule

`default_nettype wire

// ===== sv/usrc_checker.sv =====
// ----------------------------------------------------------------------------
// usrc_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module usrc_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic                                  rsp_symbol_accepted,
   input wire logic                                  rsp_utf8_well_formed,
   input wire logic [usrc_pkg::CodePointWidth-1:0]   rsp_code_point,
   input wire logic [usrc_pkg::RangeIdxWidth-1:0]    rsp_matched_range
);

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point) &&
      $stable(rsp_matched_range) && $stable(rsp_symbol_accepted) &&
      $stable(rsp_utf8_well_formed))
      else $error("response changed while stalled");

   a_malformed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_utf8_well_formed |->
      rsp_code_point == '0 && rsp_matched_range == usrc_pkg::NoRange &&
      !rsp_symbol_accepted)
      else $error("malformed symbol with non-null result");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol_accepted ==
      (rsp_utf8_well_formed && rsp_matched_range != usrc_pkg::NoRange))
      else $error("verdict disagrees with matched range");

   a_range_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched_range != usrc_pkg::NoRange |->
      rsp_code_point >= usrc_pkg::RangeLo[rsp_matched_range] &&
      rsp_code_point <= usrc_pkg::RangeHi[rsp_matched_range])
      else $error("code point outside reported range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind utf8_symbol_range_checker_unit usrc_checker u_usrc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_symbol_accepted  (rsp_symbol_accepted),
   .rsp_utf8_well_formed (rsp_utf8_well_formed),
   .rsp_code_point       (rsp_code_point),
   .rsp_matched_range    (rsp_matched_range)
);

`default_nettype wire
